// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; clk and rst_n are taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset
`define TAS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: always");

// Consequent must hold in the same cycle as the antecedent
`define TAS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent
`define TAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/tas_pkg.sv -----
// Types, register map and stage codes of the throttle arming sequencer
`default_nettype none

package tas_pkg;

  // Arming stages
  localparam logic [2:0] STG_FREE  = 3'd0;
  localparam logic [2:0] STG_HIGH  = 3'd1;
  localparam logic [2:0] STG_WAIT  = 3'd2;
  localparam logic [2:0] STG_LOW   = 3'd3;
  localparam logic [2:0] STG_ARMED = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_HIGH_TH  = 3'd0;
  localparam logic [2:0] REG_LOW_TH   = 3'd1;
  localparam logic [2:0] REG_YAW_TH   = 3'd2;
  localparam logic [2:0] REG_HOLD     = 3'd3;
  localparam logic [2:0] REG_AUTOLOCK = 3'd4;

  // Reset values
  localparam logic [15:0] RST_HIGH_TH  = 16'd960;
  localparam logic [15:0] RST_LOW_TH   = 16'd20;
  localparam logic [15:0] RST_YAW_TH   = 16'd600;
  localparam logic [7:0]  RST_HOLD     = 8'd200;
  localparam logic [15:0] RST_AUTOLOCK = 16'd2000;

  localparam int CFG_AW = 5;
  localparam int IN_DW  = 40;
  localparam int OUT_DW = 8;

  typedef struct packed {
    logic [15:0] high_th;
    logic [15:0] low_th;
    logic [15:0] yaw_th;
    logic [7:0]  hold_ticks;
    logic [15:0] autolock_ticks;
  } tas_cfg_t;

  typedef struct packed {
    logic [2:0]  stage;
    logic [7:0]  high_cnt;
    logic [7:0]  low_cnt;
    logic [15:0] idle_cnt;
    logic        hold;
  } tas_state_t;

  typedef struct packed {
    logic       connected;
    logic [15:0] throttle;
    logic [15:0] yaw;
    logic       toggle_request;
  } tas_tick_t;

  typedef struct packed {
    logic       unlocked;
    logic       hold_mode;
    logic [2:0] stage;
  } tas_result_t;

endpackage

`default_nettype wire

// ----- rtl/tas_step.sv -----
// Next-state and result logic for one control tick of the arming sequence
`default_nettype none

module tas_step
  import tas_pkg::*;
(
  input  wire tas_cfg_t    cfg,
  input  wire tas_state_t  cur,
  input  wire tas_tick_t   tick,
  output tas_state_t       nxt,
  output tas_result_t      res
);

  logic        is_high;
  logic        is_low;
  logic        ok;
  logic [7:0]  high_inc;
  logic [7:0]  low_inc;
  logic [15:0] idle_inc;

  assign is_high  = tick.throttle >= cfg.high_th;
  assign is_low   = tick.throttle <= cfg.low_th;
  assign high_inc = (cur.high_cnt == 8'hFF) ? cur.high_cnt : cur.high_cnt + 8'd1;
  assign low_inc  = (cur.low_cnt == 8'hFF) ? cur.low_cnt : cur.low_cnt + 8'd1;
  assign idle_inc = (cur.idle_cnt == 16'hFFFF) ? cur.idle_cnt : cur.idle_cnt + 16'd1;

  always_comb begin
    nxt = cur;
    ok  = 1'b0;
    if (!tick.connected) begin
      nxt.stage = STG_FREE;
    end else begin
      case (cur.stage)
        STG_HIGH: begin
          if (is_high) begin
            nxt.high_cnt = high_inc;
            if (high_inc >= cfg.hold_ticks) nxt.stage = STG_WAIT;
          end else begin
            nxt.stage = STG_FREE;
          end
        end
        STG_WAIT: begin
          if (is_low) nxt.stage = STG_LOW;
        end
        STG_LOW: begin
          if (is_low) begin
            nxt.low_cnt = low_inc;
            if (low_inc >= cfg.hold_ticks) nxt.stage = STG_ARMED;
          end else begin
            nxt.stage = STG_FREE;
          end
        end
        STG_ARMED: begin
          ok = 1'b1;
          if (is_low) begin
            if (tick.yaw >= cfg.yaw_th) nxt.stage = STG_FREE;
            nxt.idle_cnt = idle_inc;
            // timeout wins and restarts the idle count
            if (idle_inc >= cfg.autolock_ticks) begin
              nxt.stage    = STG_FREE;
              nxt.idle_cnt = 16'd0;
            end
          end else begin
            nxt.idle_cnt = 16'd0;
          end
        end
        default: begin
          nxt.high_cnt = 8'd0;
          nxt.low_cnt  = 8'd0;
          nxt.stage    = is_high ? STG_HIGH : STG_FREE;
        end
      endcase
    end
    nxt.hold = ok ? (cur.hold ^ tick.toggle_request) : 1'b0;
  end

  assign res.unlocked  = ok;
  assign res.hold_mode = nxt.hold;
  assign res.stage     = nxt.stage;

endmodule

`default_nettype wire

// ----- rtl/throttle_arming_sequencer_core.sv -----
// Top level of the throttle arming sequencer: config registers, tick pipeline, result register
//
// Usage:
//   Input stream (in_*): one word per control tick, carrying link state, throttle,
//   yaw and an altitude-hold toggle request. Output stream (out_*): one word per
//   tick with the armed flag of that tick, the hold mode and the arming stage.
//   Configuration (cfg_*): APB-style, five registers at byte addresses 0,4,...,16
//   (high, low and yaw thresholds, hold ticks, auto-lock ticks); write only while
//   no tick is in flight. pready is tied high; reads return the register value.
// Timing:
//   An accepted word is held in the input register, then evaluated into the result
//   register and offered on out_* from then on. One word per cycle is sustained
//   while out_tready stays high; the only loop is the state register update.
// Reset:
//   rst_n (synchronous, low) clears the pipeline, the arming state to free with
//   zero counters and hold mode off, and loads the registers with their defaults.
// Back-pressure:
//   While out_tready is low the result holds; the input register still takes one
//   more word, after which in_tready drops until the result is taken.
`default_nettype none

module throttle_arming_sequencer_core
  import tas_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  // input stream
  input  wire                 in_tvalid,
  output logic                in_tready,
  // [0] connected, [16:1] throttle, [32:17] yaw, [33] toggle_request, [39:34] zero
  input  wire  [IN_DW-1:0]    in_tdata,
  // result stream
  output logic                out_tvalid,
  input  wire                 out_tready,
  // [0] unlocked, [1] hold_mode, [4:2] stage, [7:5] zero
  output logic [OUT_DW-1:0]   out_tdata,
  // configuration port
  input  wire                 cfg_psel,
  input  wire                 cfg_penable,
  input  wire                 cfg_pwrite,
  input  wire  [CFG_AW-1:0]   cfg_paddr,
  input  wire  [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  tas_cfg_t    cfg_r;
  tas_cfg_t    cfg_nxt;
  tas_state_t  state_r;
  tas_state_t  state_nxt;
  tas_tick_t   tick_r;
  tas_result_t res_nxt;
  tas_result_t res_r;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        s1_adv;
  logic        in_acc;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_HIGH_TH:  cfg_nxt.high_th        = cfg_pwdata[15:0];
        REG_LOW_TH:   cfg_nxt.low_th         = cfg_pwdata[15:0];
        REG_YAW_TH:   cfg_nxt.yaw_th         = cfg_pwdata[15:0];
        REG_HOLD:     cfg_nxt.hold_ticks     = cfg_pwdata[7:0];
        REG_AUTOLOCK: cfg_nxt.autolock_ticks = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HIGH_TH:  cfg_prdata = {16'd0, cfg_r.high_th};
      REG_LOW_TH:   cfg_prdata = {16'd0, cfg_r.low_th};
      REG_YAW_TH:   cfg_prdata = {16'd0, cfg_r.yaw_th};
      REG_HOLD:     cfg_prdata = {24'd0, cfg_r.hold_ticks};
      REG_AUTOLOCK: cfg_prdata = {16'd0, cfg_r.autolock_ticks};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // ---------------- tick evaluation ----------------
  tas_state_t step_nxt;

  tas_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .tick (tick_r),
    .nxt  (step_nxt),
    .res  (res_nxt)
  );

  assign state_nxt = s1_adv ? step_nxt : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_th        <= RST_HIGH_TH;
      cfg_r.low_th         <= RST_LOW_TH;
      cfg_r.yaw_th         <= RST_YAW_TH;
      cfg_r.hold_ticks     <= RST_HOLD;
      cfg_r.autolock_ticks <= RST_AUTOLOCK;
      state_r.stage        <= STG_FREE;
      state_r.high_cnt     <= 8'd0;
      state_r.low_cnt      <= 8'd0;
      state_r.idle_cnt     <= 16'd0;
      state_r.hold         <= 1'b0;
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tick_r.connected      <= in_tdata[0];
      tick_r.throttle       <= in_tdata[16:1];
      tick_r.yaw            <= in_tdata[32:17];
      tick_r.toggle_request <= in_tdata[33];
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, res_r.stage, res_r.hold_mode, res_r.unlocked};

  // ---------------- assertions ----------------
  `include "assert_macros.svh"

  `TAS_ASSERT_ALWAYS(a_stage_legal, state_r.stage <= STG_ARMED)
  `TAS_ASSERT_IMPL(a_out_stage_legal, out_tvalid, out_tdata[4:2] <= STG_ARMED)
  `TAS_ASSERT_IMPL(a_hold_needs_armed, out_tvalid && !out_tdata[0], !out_tdata[1])
  `TAS_ASSERT_NEXT(a_state_idle_stable, !s1_valid_r, state_r == $past(state_r))

endmodule

`default_nettype wire

// ----- bench/tb_throttle_arming_sequencer_core.sv -----
// Self-checking bench for the throttle arming sequencer: stick sequences in, stage/armed words checked
module tb_throttle_arming_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tas_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 65;
  localparam int MAX_PRINTED  = 30;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  // Arming predictor and store of expected result words
  class arm_scoreboard;
    logic [15:0] high_th, low_th, yaw_th, autolock;
    logic [7:0]  hold;
    logic [2:0]  stage;
    logic [7:0]  high_cnt, low_cnt;
    logic [15:0] idle_cnt;
    logic        hold_flag;
    tas_result_t expected_q[$];
    int errors, ticks, results, armed_ticks, relocks, printed;

    function new();
      high_th  = RST_HIGH_TH;
      low_th   = RST_LOW_TH;
      yaw_th   = RST_YAW_TH;
      hold     = RST_HOLD;
      autolock = RST_AUTOLOCK;
      stage    = STG_FREE;
      high_cnt = '0;
      low_cnt  = '0;
      idle_cnt = '0;
      hold_flag = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_HIGH_TH:  high_th  = val[15:0];
        REG_LOW_TH:   low_th   = val[15:0];
        REG_YAW_TH:   yaw_th   = val[15:0];
        REG_HOLD:     hold     = val[7:0];
        REG_AUTOLOCK: autolock = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_tick(tas_tick_t t);
      logic is_high, is_low, armed;
      tas_result_t r;
      is_high = t.throttle >= high_th;
      is_low  = t.throttle <= low_th;
      armed   = 1'b0;
      ticks++;
      if (!t.connected) begin
        stage = STG_FREE;
      end else begin
        case (stage)
          STG_HIGH: begin
            if (is_high) begin
              if (high_cnt != 8'hFF) high_cnt++;
              if (high_cnt >= hold) stage = STG_WAIT;
            end else begin
              stage = STG_FREE;
            end
          end
          STG_WAIT: begin
            if (is_low) stage = STG_LOW;
          end
          STG_LOW: begin
            if (is_low) begin
              if (low_cnt != 8'hFF) low_cnt++;
              if (low_cnt >= hold) stage = STG_ARMED;
            end else begin
              stage = STG_FREE;
            end
          end
          STG_ARMED: begin
            armed = 1'b1;
            if (is_low) begin
              if (t.yaw >= yaw_th) stage = STG_FREE;
              if (idle_cnt != 16'hFFFF) idle_cnt++;
              if (idle_cnt >= autolock) begin
                stage = STG_FREE;
                idle_cnt = '0;
              end
            end else begin
              idle_cnt = '0;
            end
          end
          default: begin
            high_cnt = '0;
            low_cnt  = '0;
            stage = is_high ? STG_HIGH : STG_FREE;
          end
        endcase
      end
      // hold mode only survives ticks that began armed
      if (armed) begin
        if (t.toggle_request) hold_flag = ~hold_flag;
      end else begin
        hold_flag = 1'b0;
      end
      if (armed) armed_ticks++;
      if (armed && stage == STG_FREE) relocks++;
      r.unlocked  = armed;
      r.hold_mode = hold_flag;
      r.stage     = stage;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("MISMATCH %s: got %0h, expected %0h (word %0d)", what, got, want, results);
      end
    endtask

    task check_result(logic [OUT_DW-1:0] word);
      tas_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        report("result word with nothing expected", word, 0);
      end else begin
        e = expected_q.pop_front();
        if (word[0] !== e.unlocked)   report("unlocked", word[0], e.unlocked);
        if (word[1] !== e.hold_mode)  report("hold_mode", word[1], e.hold_mode);
        if (word[4:2] !== e.stage)    report("stage", word[4:2], e.stage);
        if (word[7:5] !== 3'b000)     report("padding", word[7:5], 0);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                out_tready = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  wire                 in_tready;
  wire                 out_tvalid;
  wire  [OUT_DW-1:0]   out_tdata;
  wire  [31:0]         cfg_prdata;
  wire                 cfg_pready;

  arm_scoreboard sb = new();
  logic [IN_DW-1:0] stim_q[$];
  bit long_hold_req = 1'b0;
  int long_holds = 0;
  int settings = 0;
  int cycles = 0;

  throttle_arming_sequencer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] connected, [16:1] throttle, [32:17] yaw, [33] toggle
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [0] unlocked, [1] hold_mode, [4:2] stage
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.expected_q.size());
      $display("throttle_arming_sequencer_core verification failed");
      $finish;
    end
  end

  // Monitor: both handshakes sampled at the rising edge
  always @(posedge clk) begin
    tas_tick_t t;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        t.connected      = in_tdata[0];
        t.throttle       = in_tdata[16:1];
        t.yaw            = in_tdata[32:17];
        t.toggle_request = in_tdata[33];
        sb.note_tick(t);
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request
  initial begin
    rx_mode_e mode;
    int left, hold_left;
    mode = RX_OPEN;
    left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left = $urandom_range(96, 48);
        long_hold_req = 1'b0;
        long_holds++;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(3, 0));
          left = $urandom_range(200, 40);
        end
        left--;
        case (mode)
          RX_OPEN:   out_tready = 1'b1;
          RX_RANDOM: out_tready = $urandom_range(1, 0);
          RX_SPARSE: out_tready = (left % 4 == 0);
          default:   out_tready = ($urandom_range(7, 0) != 0);
        endcase
      end
    end
  end

  function automatic logic [15:0] pick_high();
    if ($urandom_range(5, 0) == 0) return $urandom_range(1, 0) ? 16'hFFFF : sb.high_th;
    return 16'($urandom_range(65535, int'(sb.high_th)));
  endfunction

  function automatic logic [15:0] pick_low();
    if ($urandom_range(5, 0) == 0) return $urandom_range(1, 0) ? 16'h0000 : sb.low_th;
    return 16'($urandom_range(int'(sb.low_th), 0));
  endfunction

  function automatic logic [15:0] pick_mid();
    int lo, hi;
    lo = int'(sb.low_th) + 1;
    hi = int'(sb.high_th) - 1;
    if (lo <= hi) return 16'($urandom_range(hi, lo));
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic logic [15:0] pick_yaw(bit wild);
    if (wild || sb.yaw_th == 0) return 16'($urandom_range(65535, int'(sb.yaw_th)));
    return 16'($urandom_range(int'(sb.yaw_th) - 1, 0));
  endfunction

  function automatic void push(logic conn, logic [15:0] thr, logic [15:0] yaw, logic tog);
    stim_q.push_back({6'b0, tog, yaw, thr, conn});
  endfunction

  function automatic void push_noise();
    push($urandom_range(3, 0) != 0, 16'($urandom), 16'($urandom), $urandom_range(1, 0));
  endfunction

  // Arming attempt with random content (a short hold may see a mid-range break), then a stretch of armed play
  function automatic void push_arm_run();
    int n, sel;
    int hold_n;
    bit may_break;
    hold_n = (sb.hold == 0) ? 1 : sb.hold;
    may_break = hold_n <= 16;
    n = hold_n + 1 + $urandom_range(2, 0);
    for (int i = 0; i < n; i++) begin
      if (may_break && $urandom_range(39, 0) == 0) push(1'b1, pick_mid(), 16'($urandom), 1'b0);
      else push(1'b1, pick_high(), 16'($urandom), $urandom_range(1, 0));
    end
    n = $urandom_range(3, 0);
    for (int i = 0; i < n; i++) push(1'b1, pick_mid(), 16'($urandom), $urandom_range(1, 0));
    n = hold_n + 1 + $urandom_range(2, 0);
    for (int i = 0; i < n; i++) begin
      if (may_break && $urandom_range(39, 0) == 0) push(1'b1, pick_mid(), pick_yaw(0), 1'b1);
      else push(1'b1, pick_low(), pick_yaw(0), $urandom_range(1, 0));
    end
    n = $urandom_range(40, 4);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(19, 0);
      push($urandom_range(49, 0) != 0,
           (sel < 12) ? pick_low() : (sel < 17) ? pick_high() : pick_mid(),
           pick_yaw($urandom_range(9, 0) == 0), $urandom_range(1, 0));
    end
  endfunction

  task automatic send_stim();
    int burst, gap;
    while (stim_q.size() > 0) begin
      burst = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
      gap   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      for (int i = 0; i < burst && stim_q.size() > 0; i++) begin
        in_tdata  = stim_q.pop_front();
        in_tvalid = 1'b1;
        do @(posedge clk); while (!in_tready);
        @(negedge clk);
      end
      if (gap > 0) begin
        in_tvalid = 1'b0;
        in_tdata  = {8'($urandom), 32'($urandom)};
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register over the APB port, then read it back
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    logic [31:0] mask, rd;
    mask = (idx == REG_HOLD) ? 32'h0000_00FF : 32'h0000_FFFF;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_AW'({idx, 2'b00});
    cfg_pwdata  = ($urandom & ~mask) | (32'(val) & mask);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, cfg_pwdata);
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (rd !== (cfg_pwdata & mask)) sb.report("register readback", rd, cfg_pwdata & mask);
  endtask

  task automatic set_config(logic [15:0] hi, logic [15:0] lo, logic [15:0] yaw,
                            logic [7:0] hold, logic [15:0] autolock);
    wait_drain();
    write_reg(REG_HIGH_TH, hi);
    write_reg(REG_LOW_TH, lo);
    write_reg(REG_YAW_TH, yaw);
    write_reg(REG_HOLD, {8'h00, hold});
    write_reg(REG_AUTOLOCK, autolock);
    settings++;
  endtask

  initial begin
    int h;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: link loss, stick high exactly at threshold, dropping back
    push(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
    push(1'b1, 16'd0, 16'd0, 1'b0);
    push(1'b1, 16'd960, 16'd0, 1'b1);
    push(1'b1, 16'd959, 16'd0, 1'b0);
    send_stim();

    set_config(16'd960, 16'd20, 16'd600, 8'd2, 16'd3);
    // arm, toggle hold, time out on low throttle
    push(1'b1, 16'hFFFF, 16'd0, 1'b0);
    push(1'b1, 16'd960, 16'd0, 1'b0);
    push(1'b1, 16'd1000, 16'd0, 1'b0);
    push(1'b1, 16'd500, 16'd0, 1'b0);
    push(1'b1, 16'd20, 16'd0, 1'b0);
    push(1'b1, 16'd0, 16'd0, 1'b0);
    push(1'b1, 16'd20, 16'd0, 1'b0);
    push(1'b1, 16'd500, 16'd0, 1'b1);
    push(1'b1, 16'd0, 16'd599, 1'b1);
    push(1'b1, 16'd0, 16'd0, 1'b1);
    push(1'b1, 16'd0, 16'd0, 1'b0);
    push(1'b1, 16'd0, 16'd0, 1'b1);
    // re-arm, then lock on yaw exactly at threshold
    repeat (3) push(1'b1, 16'd960, 16'd0, 1'b0);
    repeat (3) push(1'b1, 16'd0, 16'd0, 1'b0);
    push(1'b1, 16'd21, 16'hFFFF, 1'b1);
    push(1'b1, 16'd20, 16'd600, 1'b1);
    push(1'b0, 16'd0, 16'd0, 1'b1);
    send_stim();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(16'd960, 16'd20, 16'd600, 8'd3, 16'd10);
        1: set_config(16'hFFFF, 16'd0, 16'hFFFF, 8'd1, 16'd1);
        2: set_config(16'd0, 16'hFFFF, 16'd0, 8'd0, 16'd0);
        3: set_config(16'd960, 16'd20, 16'd600, 8'd255, 16'hFFFF);
        4: set_config(16'd1000, 16'd1000, 16'd600, 8'd2, 16'd5);
        default: begin
          h = $urandom_range(60000, 50);
          set_config(16'(h), 16'($urandom_range(h - 1, 0)), 16'($urandom),
                     8'($urandom_range(8, 1)), 16'($urandom_range(40, 1)));
        end
      endcase
      if (p == 3) begin
        // one full arming at the longest hold time
        push_arm_run();
        repeat (10) push_noise();
      end else begin
        while (stim_q.size() < PHASE_ITEMS) begin
          if ($urandom_range(3, 0) != 0) push_arm_run();
          else repeat ($urandom_range(6, 1)) push_noise();
        end
      end
      long_hold_req = 1'b1;
      send_stim();
    end

    wait_drain();
    repeat (8) @(negedge clk);
    $display("%0d ticks over %0d register settings, %0d long receiver hold-offs",
             sb.ticks, settings, long_holds);
    $display("%0d armed ticks seen, %0d relocks, %0d mismatches",
             sb.armed_ticks, sb.relocks, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("throttle_arming_sequencer_core verification clean");
    end else begin
      $display("throttle_arming_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
